[hdl/escaped_frame_deframer_top_defines.svh]
// Assertion macros for the escaped frame deframer.
// Included by the top level; expects clk and rst_n in scope.
`ifndef ESCAPED_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define ESCAPED_FRAME_DEFRAMER_TOP_DEFINES_SVH

// same-cycle implication
`define EFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/efd_pkg.sv]
// Shared types and constants for the escaped frame deframer.
// No dependencies; used by efd_parser and escaped_frame_deframer_top.
package efd_pkg;

  localparam int BYTE_W    = 8;
  localparam int BUFID_W   = 2;
  localparam int POS_W     = 9;
  localparam int CFG_IDX_W = 2;
  localparam int MODE_W    = 2;

  // parser modes
  localparam logic [MODE_W-1:0] MODE_HUNT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FRAME = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ESC   = 2'd2;

  // event kinds
  localparam logic EVT_DATA = 1'b0;
  localparam logic EVT_DONE = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FLAG = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ESC  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK = 2'd2;

  localparam logic [BYTE_W-1:0] FLAG_RST = 8'h7E;
  localparam logic [BYTE_W-1:0] ESC_RST  = 8'h7D;
  localparam logic [BYTE_W-1:0] MASK_RST = 8'h20;

  typedef struct packed {
    logic [BYTE_W-1:0] flag_byte;
    logic [BYTE_W-1:0] escape_byte;
    logic [BYTE_W-1:0] escape_mask;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    logic               kind;
    logic [BUFID_W-1:0] buffer_id;
    logic [POS_W-1:0]   position;
    logic [BYTE_W-1:0]  data_byte;
  } evt_t;

endpackage

[hdl/efd_parser.sv]
// Deframer state machine: mode, fill count and buffer number, one byte per step.
// Depends on efd_pkg; the event is combinational and registered by the top level.
module efd_parser #(
  parameter int MAX_FRAME_BYTES = 256,
  parameter int NUM_BUFFERS     = 4,
  localparam int FILL_W = $clog2(MAX_FRAME_BYTES + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,
  input  logic [efd_pkg::BYTE_W-1:0] byte_i,
  input  logic                      err_i,
  input  efd_pkg::cfg_t             cfg,
  output efd_pkg::evt_t             evt,
  output logic [FILL_W-1:0]         fill_o
);

  localparam int BUFN_W = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam logic [FILL_W-1:0] FILL_MAX  = FILL_W'(MAX_FRAME_BYTES);
  localparam logic [BUFN_W-1:0] BUFN_LAST = BUFN_W'(NUM_BUFFERS - 1);

  logic [efd_pkg::MODE_W-1:0] mode_r, mode_nxt, mode_eff;
  logic [FILL_W-1:0]          fill_r, fill_nxt, fill_eff;
  logic [BUFN_W-1:0]          bufn_r, bufn_nxt;
  efd_pkg::evt_t              ev;

  always_comb begin
    // full frame drops back to hunting before the byte is handled
    if (fill_r >= FILL_MAX) begin
      mode_eff = efd_pkg::MODE_HUNT;
      fill_eff = '0;
    end else begin
      mode_eff = mode_r;
      fill_eff = fill_r;
    end

    mode_nxt = mode_eff;
    fill_nxt = fill_eff;
    bufn_nxt = bufn_r;
    ev       = '0;
    ev.buffer_id = efd_pkg::BUFID_W'(bufn_r);

    unique case (mode_eff)
      efd_pkg::MODE_ESC: begin
        ev.valid     = 1'b1;
        ev.kind      = efd_pkg::EVT_DATA;
        ev.position  = efd_pkg::POS_W'(fill_eff);
        ev.data_byte = byte_i ^ cfg.escape_mask;
        fill_nxt     = fill_eff + 1'b1;
        mode_nxt     = efd_pkg::MODE_FRAME;
      end
      efd_pkg::MODE_FRAME: begin
        if (byte_i == cfg.escape_byte) begin
          mode_nxt = efd_pkg::MODE_ESC;
        end else if (byte_i == cfg.flag_byte) begin
          if (fill_eff != '0) begin
            ev.valid    = 1'b1;
            ev.kind     = efd_pkg::EVT_DONE;
            ev.position = efd_pkg::POS_W'(fill_eff);
            bufn_nxt    = (bufn_r == BUFN_LAST) ? '0 : bufn_r + 1'b1;
            mode_nxt    = efd_pkg::MODE_HUNT;
          end
          fill_nxt = '0;
        end else begin
          ev.valid     = 1'b1;
          ev.kind      = efd_pkg::EVT_DATA;
          ev.position  = efd_pkg::POS_W'(fill_eff);
          ev.data_byte = byte_i;
          fill_nxt     = fill_eff + 1'b1;
        end
      end
      default: begin
        mode_nxt = efd_pkg::MODE_HUNT;
        if (byte_i == cfg.flag_byte) begin
          mode_nxt = efd_pkg::MODE_FRAME;
          fill_nxt = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= efd_pkg::MODE_HUNT;
      fill_r <= '0;
      bufn_r <= '0;
    end else if (step && !err_i) begin
      mode_r <= mode_nxt;
      fill_r <= fill_nxt;
      bufn_r <= bufn_nxt;
    end
  end

  always_comb begin
    evt       = ev;
    evt.valid = ev.valid && !err_i;
  end

  assign fill_o = fill_r;

endmodule

[hdl/escaped_frame_deframer_top.sv]
// Escaped frame deframer, top level: stream ports, config registers, result register.
// Depends on efd_pkg, efd_parser and escaped_frame_deframer_top_defines.svh.
//
// Takes one received byte per cycle and delivers at most one event per byte,
// in the cycle after the transfer, from a single output register. Input ready
// drops only while that register holds an event the sink has not taken, so
// with out_tready high the block sustains one byte per clock. Bytes with a
// line error are dropped without changing state. Each stored byte comes out
// as a data event (buffer, position, unescaped byte); a closing flag after a
// non-empty frame gives a completion event carrying the frame length, and the
// buffer number then advances modulo NUM_BUFFERS. Configuration writes are
// meant to happen while no event is pending.
`include "escaped_frame_deframer_top_defines.svh"

module escaped_frame_deframer_top #(
  parameter int MAX_FRAME_BYTES = 256,
  parameter int NUM_BUFFERS     = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] rx_byte
  input  logic [0:0]                     in_tuser,   // [0] line_error
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [23:0]                    out_tdata,  // [1:0] buffer_id, [10:2] position,
                                                     // [18:11] data_byte, [23:19] zero
  output logic [0:0]                     out_tuser,  // [0] event_kind
  // configuration
  input  logic                           cfg_we,
  input  logic [efd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [efd_pkg::BYTE_W-1:0]     cfg_wdata
);

  localparam int FILL_W = $clog2(MAX_FRAME_BYTES + 1);

  efd_pkg::cfg_t      cfg_r;
  efd_pkg::evt_t      evt;
  logic [FILL_W-1:0]  fill;
  logic               in_xfer;
  logic               out_valid_r;
  logic [23:0]        out_data_r;
  logic               out_kind_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flag_byte   <= efd_pkg::FLAG_RST;
      cfg_r.escape_byte <= efd_pkg::ESC_RST;
      cfg_r.escape_mask <= efd_pkg::MASK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        efd_pkg::CFG_FLAG: cfg_r.flag_byte   <= cfg_wdata;
        efd_pkg::CFG_ESC:  cfg_r.escape_byte <= cfg_wdata;
        efd_pkg::CFG_MASK: cfg_r.escape_mask <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  efd_parser #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
    .NUM_BUFFERS     (NUM_BUFFERS)
  ) u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (in_xfer),
    .byte_i (in_tdata),
    .err_i  (in_tuser[0]),
    .cfg    (cfg_r),
    .evt    (evt),
    .fill_o (fill)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= evt.valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && evt.valid) begin
      out_data_r <= {5'd0, evt.data_byte, evt.position, evt.buffer_id};
      out_kind_r <= evt.kind;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_kind_r;

  `EFD_ASSERT_NOW(a_fill_bound, 1'b1, fill <= FILL_W'(MAX_FRAME_BYTES), "fill count past frame limit")
  `EFD_ASSERT_NEXT(a_err_no_evt, in_xfer && in_tuser[0], !out_valid_r, "event from errored byte")
  `EFD_ASSERT_NOW(a_done_zero, out_valid_r && out_tuser[0] == efd_pkg::EVT_DONE, out_tdata[18:11] == 8'd0, "completion with data")

endmodule

[tb/sv/efd_event_checker.sv]
// Scoreboard for the escaped frame deframer: tracks config writes, predicts events per byte.
// Depends on efd_pkg; instantiated next to the DUT by escaped_frame_deframer_top_tb.
module efd_event_checker #(
  parameter int MAX_FRAME_BYTES = 256,
  parameter int NUM_BUFFERS     = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] rx_byte
  input  logic [0:0]                     in_tuser,   // [0] line_error
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [23:0]                    out_tdata,  // [1:0] buffer_id, [10:2] position,
                                                     // [18:11] data_byte, [23:19] zero
  input  logic [0:0]                     out_tuser,  // [0] event_kind
  input  logic                           cfg_we,
  input  logic [efd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [efd_pkg::BYTE_W-1:0]     cfg_wdata,
  output int                             fails,
  output int                             pending,
  output int                             frames_done
);
  timeunit 1ns;
  timeprecision 1ps;
  import efd_pkg::*;

  typedef struct packed {
    logic               kind;
    logic [BUFID_W-1:0] buffer_id;
    logic [POS_W-1:0]   position;
    logic [BYTE_W-1:0]  data_byte;
  } frame_event_t;

  logic [BYTE_W-1:0] flag_q, esc_q, mask_q;
  logic [MODE_W-1:0] mode_q;
  int unsigned       fill_q;
  int unsigned       buf_q;
  frame_event_t      expected_events[$];

  function automatic frame_event_t make_event(input logic kind, input int unsigned pos,
                                              input logic [BYTE_W-1:0] data);
    frame_event_t ev;
    ev.kind      = kind;
    ev.buffer_id = BUFID_W'(buf_q);
    ev.position  = POS_W'(pos);
    ev.data_byte = data;
    return ev;
  endfunction

  // advances the parser state by one byte; returns 1 when the byte yields an event
  function automatic bit deframe_byte(input logic [BYTE_W-1:0] rx, input logic err,
                                      output frame_event_t ev);
    ev = '0;
    if (err) return 1'b0;
    if (fill_q >= MAX_FRAME_BYTES) begin
      mode_q = MODE_HUNT;
      fill_q = 0;
    end
    case (mode_q)
      MODE_ESC: begin
        ev = make_event(EVT_DATA, fill_q, rx ^ mask_q);
        fill_q++;
        mode_q = MODE_FRAME;
        return 1'b1;
      end
      MODE_FRAME: begin
        if (rx == esc_q) begin
          mode_q = MODE_ESC;
          return 1'b0;
        end
        if (rx == flag_q) begin
          if (fill_q != 0) begin
            ev = make_event(EVT_DONE, fill_q, '0);
            buf_q = (buf_q + 1) % NUM_BUFFERS;
            mode_q = MODE_HUNT;
            fill_q = 0;
            return 1'b1;
          end
          fill_q = 0;
          return 1'b0;
        end
        ev = make_event(EVT_DATA, fill_q, rx);
        fill_q++;
        return 1'b1;
      end
      default: begin
        mode_q = MODE_HUNT;
        if (rx == flag_q) begin
          mode_q = MODE_FRAME;
          fill_q = 0;
        end
        return 1'b0;
      end
    endcase
  endfunction

  task automatic report_mismatch(input string field, input int exp_val, input int act_val);
    fails++;
    $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, field, exp_val, act_val);
  endtask

  always @(posedge clk) begin
    frame_event_t ev;
    frame_event_t got;
    if (!rst_n) begin
      flag_q = FLAG_RST;
      esc_q  = ESC_RST;
      mask_q = MASK_RST;
      mode_q = MODE_HUNT;
      fill_q = 0;
      buf_q  = 0;
      expected_events.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FLAG: flag_q = cfg_wdata;
          CFG_ESC:  esc_q  = cfg_wdata;
          CFG_MASK: mask_q = cfg_wdata;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.kind      = out_tuser[0];
        got.buffer_id = out_tdata[1:0];
        got.position  = out_tdata[10:2];
        got.data_byte = out_tdata[18:11];
        if (expected_events.size() == 0) begin
          fails++;
          $display("%0t: unexpected event, expected none actual kind %0d buf %0d pos %0d data 0x%0h",
                   $time, got.kind, got.buffer_id, got.position, got.data_byte);
        end else begin
          ev = expected_events.pop_front();
          if (ev.kind == EVT_DONE) frames_done++;
          if (got.kind !== ev.kind) report_mismatch("event_kind", ev.kind, got.kind);
          if (got.buffer_id !== ev.buffer_id)
            report_mismatch("buffer_id", ev.buffer_id, got.buffer_id);
          if (got.position !== ev.position)
            report_mismatch("position", ev.position, got.position);
          if (got.data_byte !== ev.data_byte)
            report_mismatch("data_byte", ev.data_byte, got.data_byte);
          if (out_tdata[23:19] !== 5'd0) report_mismatch("tdata pad", 0, out_tdata[23:19]);
        end
      end
      if (in_tvalid && in_tready && deframe_byte(in_tdata, in_tuser[0], ev))
        expected_events.push_back(ev);
    end
    pending = expected_events.size();
  end

endmodule

[tb/sv/escaped_frame_deframer_top_tb.sv]
// Top-level testbench for the escaped frame deframer: clock, reset, byte stimulus, sink stalls.
// Depends on efd_pkg, escaped_frame_deframer_top and efd_event_checker.
module escaped_frame_deframer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import efd_pkg::*;

  localparam int MAX_FRAME_BYTES = 256;
  localparam int NUM_BUFFERS     = 4;
  localparam int IDLE_LIMIT      = 2000;
  localparam int HOLD_CYCLES     = 150;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata   = '0;
  logic [0:0]           in_tuser   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [23:0]          out_tdata;
  logic [0:0]           out_tuser;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = CFG_FLAG;
  logic [BYTE_W-1:0]    cfg_wdata  = '0;

  int fails;
  int pending;
  int frames_done;

  logic [BYTE_W-1:0] cur_flag = FLAG_RST;
  logic [BYTE_W-1:0] cur_esc  = ESC_RST;
  logic [BYTE_W-1:0] cur_mask = MASK_RST;
  int sent        = 0;
  int settings    = 1;
  int idle_cycles = 0;

  always #1 clk = ~clk;

  escaped_frame_deframer_top #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
    .NUM_BUFFERS(NUM_BUFFERS)
  ) DUT (.*);

  efd_event_checker #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
    .NUM_BUFFERS(NUM_BUFFERS)
  ) event_chk (.*);

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int idle_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [BYTE_W-1:0] plain_byte();
    logic [BYTE_W-1:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == cur_flag || b == cur_esc);
    return b;
  endfunction

  // sink: random stalls, plus a long hold-off now and then to back up the input
  initial begin : sink
    int taken;
    int next_hold;
    int hold_left;
    int gap_left;
    taken     = 0;
    next_hold = 100;
    hold_left = 0;
    gap_left  = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) taken++;
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (taken >= next_hold) begin
        out_tready <= 1'b0;
        hold_left = HOLD_CYCLES;
        next_hold += 400;
      end else if (gap_left > 0) begin
        out_tready <= 1'b0;
        gap_left--;
      end else begin
        out_tready <= 1'b1;
        gap_left = idle_gap((taken / 64) % 3 == 0);
      end
    end
  end

  task automatic send(input logic [BYTE_W-1:0] b, input logic err);
    int gap;
    gap = idle_gap((sent / 48) % 4 == 0);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= err;
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  task automatic apply_settings(input logic [BYTE_W-1:0] flag, input logic [BYTE_W-1:0] esc,
                                input logic [BYTE_W-1:0] mask);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (3) @(posedge clk);
    cur_flag = flag;
    cur_esc  = esc;
    cur_mask = mask;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FLAG;
    cfg_wdata <= flag;
    @(posedge clk);
    cfg_index <= CFG_ESC;
    cfg_wdata <= esc;
    @(posedge clk);
    cfg_index <= CFG_MASK;
    cfg_wdata <= mask;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings++;
  endtask

  task automatic send_content();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      send(cur_esc, 1'b0);
      if (r < 3) send(8'($urandom_range(0, 255)), 1'b1);
      send(8'($urandom_range(0, 255)), 1'b0);
    end else if (r < 12) begin
      send(cur_esc, 1'b0);
      send(cur_flag, 1'b0);
    end else if (r < 16) begin
      send((r < 14) ? cur_flag : cur_esc, 1'b1);
    end else if (r < 19) begin
      send(8'($urandom_range(0, 255)), 1'b1);
    end else begin
      send(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  task automatic random_traffic(input int n_items);
    int stop;
    int r;
    int len;
    stop = sent + n_items;
    while (sent < stop) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        repeat ($urandom_range(1, 4))
          send(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else if (r < 14) begin
        send(cur_flag, 1'b0);
      end else begin
        len = (r < 22) ? $urandom_range(13, 40) : $urandom_range(0, 10);
        send(cur_flag, 1'b0);
        repeat (len) send_content();
        if (r % 8 != 0) send(cur_flag, 1'b0);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners at reset settings
    send(8'h00, 1'b0);        // hunting, ignored
    send(FLAG_RST, 1'b1);     // flag with line error dropped
    send(8'hFF, 1'b0);
    send(FLAG_RST, 1'b0);     // open
    send(FLAG_RST, 1'b0);     // empty frame, stays open
    send(8'h00, 1'b0);
    send(8'hFF, 1'b0);
    send(FLAG_RST, 1'b1);
    send(ESC_RST, 1'b0);
    send(8'h5E, 1'b0);        // unescapes to flag
    send(ESC_RST, 1'b0);
    send(8'h5D, 1'b0);
    send(ESC_RST, 1'b0);
    send(FLAG_RST, 1'b0);     // escaped raw flag is stored
    send(ESC_RST, 1'b0);
    send(8'h33, 1'b1);        // error inside escape keeps escape pending
    send(8'h01, 1'b0);
    send(FLAG_RST, 1'b0);     // close
    send(8'hAA, 1'b0);
    send(FLAG_RST, 1'b0);
    send(8'h80, 1'b0);
    send(FLAG_RST, 1'b0);

    random_traffic(40);

    // full frame ending on an escaped byte, then a flag that opens a new frame
    send(cur_flag, 1'b0);
    repeat (MAX_FRAME_BYTES - 1) send(plain_byte(), 1'b0);
    send(cur_esc, 1'b0);
    send(plain_byte(), 1'b0);
    send(cur_flag, 1'b0);
    send(plain_byte(), 1'b0);
    send(plain_byte(), 1'b0);
    send(cur_flag, 1'b0);
    // overrun: bytes past the limit drop back to hunting
    send(cur_flag, 1'b0);
    repeat (MAX_FRAME_BYTES + 3) send(plain_byte(), 1'b0);
    send(cur_flag, 1'b0);
    send(plain_byte(), 1'b0);
    send(cur_flag, 1'b0);

    apply_settings(8'h00, 8'hFF, 8'hFF);
    random_traffic(25);
    apply_settings(8'hFF, 8'h00, 8'h00);
    random_traffic(25);
    apply_settings(8'h55, 8'h55, 8'hAA);  // escape shadows flag inside frames
    random_traffic(25);
    apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
    random_traffic(25);
    apply_settings(FLAG_RST, ESC_RST, MASK_RST);
    random_traffic(25);

    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (6) @(posedge clk);

    $display("tb: %0d bytes sent under %0d register settings, %0d frames closed",
             sent, settings, frames_done);
    $display("tb: covered escapes, line errors, empty and oversize frames, sink back-pressure");
    if (fails == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
